/* rtl/svp_pkg.sv */
// svp_pkg: shared types and constants for the semantic version parser.
// No dependencies; imported by svp_parse, the top level, the checker and the testbench.
package svp_pkg;

	localparam int CHAR_W = 8;
	localparam int PART_W = 20;
	localparam int STATUS_W = 2;
	// A part times ten plus a digit needs 24 bits before the range check.
	localparam int WIDE_W = 24;

	localparam logic [PART_W-1:0] PART_MAX = PART_W'(999999);
	localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	localparam logic [1:0] LAST_PART = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_MALFORMED = 2'd2
	} status_t;

	typedef struct packed {
		status_t status;
		logic [PART_W-1:0] major;
		logic [PART_W-1:0] minor;
		logic [PART_W-1:0] patch;
	} svp_result_t;

endpackage

/* rtl/svp_parse.sv */
// svp_parse: per-string parse state and its one-character update.
// Depends on svp_pkg; instantiated by semantic_version_parser_top.
module svp_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [svp_pkg::CHAR_W-1:0] char_code,
	output svp_pkg::svp_result_t      result
);
	import svp_pkg::*;

	logic [1:0]        part_index_q, part_index_n;
	logic [PART_W-1:0] part_accum_q, part_accum_n;
	logic              digits_seen_q, digits_seen_n;
	logic              leading_zero_q, leading_zero_n;
	logic              any_char_seen_q, any_char_seen_n;
	logic              error_flag_q, error_flag_n;
	logic [PART_W-1:0] major_hold_q, major_hold_n;
	logic [PART_W-1:0] minor_hold_q, minor_hold_n;

	logic              is_nul;
	logic              is_digit;
	logic              is_dot;
	logic [3:0]        digit;
	logic [WIDE_W-1:0] accum_next;

	assign is_nul = (char_code == CHAR_NUL);
	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign is_dot = (char_code == CHAR_DOT);
	assign digit = char_code[3:0];
	// times ten as shift-and-add
	assign accum_next = {1'b0, part_accum_q, 3'b000} + {3'b000, part_accum_q, 1'b0}
		+ {{(WIDE_W-4){1'b0}}, digit};

	always_comb begin
		part_index_n = part_index_q;
		part_accum_n = part_accum_q;
		digits_seen_n = digits_seen_q;
		leading_zero_n = leading_zero_q;
		any_char_seen_n = any_char_seen_q;
		error_flag_n = error_flag_q;
		major_hold_n = major_hold_q;
		minor_hold_n = minor_hold_q;
		if (step) begin
			if (is_nul) begin
				// terminator: start the next string clean
				part_index_n = '0;
				part_accum_n = '0;
				digits_seen_n = 1'b0;
				leading_zero_n = 1'b0;
				any_char_seen_n = 1'b0;
				error_flag_n = 1'b0;
				major_hold_n = '0;
				minor_hold_n = '0;
			end else begin
				any_char_seen_n = 1'b1;
				if (!error_flag_q) begin
					if (is_digit) begin
						if (digits_seen_q && leading_zero_q) begin
							error_flag_n = 1'b1;
						end else if (accum_next > {{(WIDE_W-PART_W){1'b0}}, PART_MAX}) begin
							error_flag_n = 1'b1;
						end else begin
							if (!digits_seen_q) begin
								leading_zero_n = (digit == 4'd0);
							end
							part_accum_n = accum_next[PART_W-1:0];
							digits_seen_n = 1'b1;
						end
					end else if (is_dot) begin
						if (!digits_seen_q || part_index_q >= LAST_PART) begin
							error_flag_n = 1'b1;
						end else begin
							if (part_index_q == 2'd0) begin
								major_hold_n = part_accum_q;
							end else begin
								minor_hold_n = part_accum_q;
							end
							part_index_n = part_index_q + 2'd1;
							part_accum_n = '0;
							digits_seen_n = 1'b0;
							leading_zero_n = 1'b0;
						end
					end else begin
						error_flag_n = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_index_q <= '0;
			part_accum_q <= '0;
			digits_seen_q <= 1'b0;
			leading_zero_q <= 1'b0;
			any_char_seen_q <= 1'b0;
			error_flag_q <= 1'b0;
			major_hold_q <= '0;
			minor_hold_q <= '0;
		end else begin
			part_index_q <= part_index_n;
			part_accum_q <= part_accum_n;
			digits_seen_q <= digits_seen_n;
			leading_zero_q <= leading_zero_n;
			any_char_seen_q <= any_char_seen_n;
			error_flag_q <= error_flag_n;
			major_hold_q <= major_hold_n;
			minor_hold_q <= minor_hold_n;
		end
	end

	// Result as it stands if the current character is the terminator.
	always_comb begin
		result.major = '0;
		result.minor = '0;
		result.patch = '0;
		if (!any_char_seen_q) begin
			result.status = STATUS_EMPTY;
		end else if (error_flag_q || part_index_q != LAST_PART || !digits_seen_q) begin
			result.status = STATUS_MALFORMED;
		end else begin
			result.status = STATUS_OK;
			result.major = major_hold_q;
			result.minor = minor_hold_q;
			result.patch = part_accum_q;
		end
	end

endmodule

/* rtl/semantic_version_parser_top.sv */
// Semantic version parser, one character per word on the input channel. A zero
// byte ends a string and yields one result word (status, major, minor, patch);
// other characters yield nothing. The block takes one character every clock
// unless in_stall is raised: each character passes an input register, then a
// registered update of the parse state (digit check, multiply by ten plus add,
// range compare). A result word is loaded into the output register when its
// terminator leaves the input register; it is held there while it waits, so
// input keeps flowing; the input stalls only when a second terminator reaches
// the parser before the previous result has been taken.
// Depends on svp_pkg and svp_parse.
module semantic_version_parser_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [svp_pkg::CHAR_W-1:0]   char_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [svp_pkg::STATUS_W-1:0] status,
	output logic [svp_pkg::PART_W-1:0]   major,
	output logic [svp_pkg::PART_W-1:0]   minor,
	output logic [svp_pkg::PART_W-1:0]   patch
);
	import svp_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              nul_s1;
	logic              block_s1;
	logic              advance;
	svp_result_t       result;
	logic              out_valid_q;
	svp_result_t       result_q;

	assign nul_s1 = (char_s1 == CHAR_NUL);
	// hold a terminator while the previous result is still waiting
	assign block_s1 = valid_s1 && nul_s1 && out_valid_q && out_stall;
	assign advance = valid_s1 && !block_s1;
	assign in_stall = block_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!block_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!block_s1 && in_valid) begin
			char_s1 <= char_code;
		end
	end

	svp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && nul_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && nul_s1) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign status = result_q.status;
	assign major = result_q.major;
	assign minor = result_q.minor;
	assign patch = result_q.patch;

endmodule

/* rtl/svp_checker.sv */
// svp_checker: port-level assertions for semantic_version_parser_top.
// Depends on svp_pkg; attached to the top level by the bind at the end.
module svp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [svp_pkg::CHAR_W-1:0]   char_code,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [svp_pkg::STATUS_W-1:0] status,
	input logic [svp_pkg::PART_W-1:0]   major,
	input logic [svp_pkg::PART_W-1:0]   minor,
	input logic [svp_pkg::PART_W-1:0]   patch
);
	import svp_pkg::*;

	// a waiting result word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(major)
			&& $stable(minor) && $stable(patch))
		else $error("result word changed while stalled");

	// a fresh result follows an accepted terminator, by way of the input and output registers
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && char_code == CHAR_NUL, 2))
		else $error("result without a terminator");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> major == '0 && minor == '0 && patch == '0)
		else $error("nonzero parts on a failed parse");

	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> major <= PART_MAX && minor <= PART_MAX && patch <= PART_MAX)
		else $error("part out of range");

endmodule

bind semantic_version_parser_top svp_checker u_svp_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for semantic_version_parser_top.
// Depends on svp_pkg and the parser RTL; checks results by parse model or typed row.
module testbench;
	import svp_pkg::*;

	localparam int RANDOM_CHARS = 2000;
	localparam int LONG_HOLD = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int DIR_ROWS = 18;

	localparam svp_result_t R_EMPTY = '{STATUS_EMPTY, '0, '0, '0};
	localparam svp_result_t R_BAD = '{STATUS_MALFORMED, '0, '0, '0};
	localparam svp_result_t R_NONE = '{STATUS_OK, '0, '0, '0};

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CHAR_W-1:0] char_code = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [PART_W-1:0] major;
	logic [PART_W-1:0] minor;
	logic [PART_W-1:0] patch;

	semantic_version_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.major(major),
		.minor(minor),
		.patch(patch)
	);

	// Directed strings; rows with a typed result skip the parse model for their result.
	string dir_text [DIR_ROWS] = '{
		"", "0.0.0", "999999.999999.999999", "1.2.3",
		"1000000.0.0", "01.2.3", "00", ".1.2",
		"1..2", "1.2.3.", "1.2", "1.2.",
		"1.2.3a", "/:~", "\001\377", "12.0.345",
		"10.20.30", "7.0.99999"
	};
	bit dir_typed [DIR_ROWS] = '{
		1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0
	};
	svp_result_t dir_want [DIR_ROWS] = '{
		R_EMPTY,
		'{STATUS_OK, 20'd0, 20'd0, 20'd0},
		'{STATUS_OK, 20'd999999, 20'd999999, 20'd999999},
		'{STATUS_OK, 20'd1, 20'd2, 20'd3},
		R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD,
		R_NONE, R_NONE, R_NONE
	};

	svp_result_t pending_versions[$];
	int mismatches = 0;
	int results_taken = 0;
	int chars_sent = 0;
	bit in_quiet = 1'b0;

	// parse model state
	logic [1:0] p_index;
	logic [PART_W-1:0] p_accum;
	logic [PART_W-1:0] p_major;
	logic [PART_W-1:0] p_minor;
	bit p_digits;
	bit p_lead_zero;
	bit p_any;
	bit p_error;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_parser();
		p_index = '0;
		p_accum = '0;
		p_major = '0;
		p_minor = '0;
		p_digits = 1'b0;
		p_lead_zero = 1'b0;
		p_any = 1'b0;
		p_error = 1'b0;
	endtask

	task automatic parse_char(input logic [CHAR_W-1:0] c, output bit fired,
			output svp_result_t res);
		logic [WIDE_W-1:0] wide;
		logic [3:0] digit;
		fired = 1'b0;
		res = R_NONE;
		if (c == CHAR_NUL) begin
			fired = 1'b1;
			if (!p_any)
				res.status = STATUS_EMPTY;
			else if (p_error || p_index != LAST_PART || !p_digits)
				res.status = STATUS_MALFORMED;
			else begin
				res.major = p_major;
				res.minor = p_minor;
				res.patch = p_accum;
			end
			clear_parser();
		end else begin
			p_any = 1'b1;
			if (!p_error) begin
				if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
					digit = 4'(c - CHAR_ZERO);
					wide = WIDE_W'(p_accum) * WIDE_W'(10) + WIDE_W'(digit);
					if (p_digits && p_lead_zero)
						p_error = 1'b1;
					else if (wide > WIDE_W'(PART_MAX))
						p_error = 1'b1;
					else begin
						if (!p_digits)
							p_lead_zero = (digit == 4'd0);
						p_accum = wide[PART_W-1:0];
						p_digits = 1'b1;
					end
				end else if (c == CHAR_DOT) begin
					if (!p_digits || p_index >= LAST_PART)
						p_error = 1'b1;
					else begin
						if (p_index == 2'd0)
							p_major = p_accum;
						else
							p_minor = p_accum;
						p_index = p_index + 2'd1;
						p_accum = '0;
						p_digits = 1'b0;
						p_lead_zero = 1'b0;
					end
				end else begin
					p_error = 1'b1;
				end
			end
		end
	endtask

	// Drop valid only when a gap follows, so valid is never lowered and raised in one step.
	task automatic send_char(input logic [CHAR_W-1:0] c);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_version(input logic [CHAR_W-1:0] chars[$], input bit typed,
			input svp_result_t want);
		bit fired;
		svp_result_t res;
		for (int i = 0; i < chars.size(); i++) begin
			send_char(chars[i]);
			parse_char(chars[i], fired, res);
		end
		send_char(CHAR_NUL);
		parse_char(CHAR_NUL, fired, res);
		pending_versions.push_back(typed ? want : res);
	endtask

	function automatic string part_text();
		int n;
		int lo;
		int hi;
		case ($urandom_range(0, 9))
			0: return "0";
			1: return "999999";
			default: begin
				n = $urandom_range(1, 6);
				lo = (n == 1) ? 0 : 10 ** (n - 1);
				hi = 10 ** n - 1;
				return $sformatf("%0d", $urandom_range(lo, hi));
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	initial begin : stimulus
		logic [CHAR_W-1:0] text[$];
		string s;
		int kind;
		clear_parser();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			text = {};
			for (int i = 0; i < dir_text[r].len(); i++)
				text.push_back(dir_text[r][i]);
			send_version(text, dir_typed[r], dir_want[r]);
		end

		// mostly well-formed versions, some broken ones, some noise
		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS) begin
			if ($urandom_range(0, 7) == 0)
				in_quiet = !in_quiet;
			kind = $urandom_range(0, 99);
			text = {};
			if (kind < 5) begin
				// empty string
			end else if (kind < 15) begin
				repeat ($urandom_range(1, 6))
					text.push_back(CHAR_W'($urandom_range(1, 255)));
			end else begin
				s = {part_text(), ".", part_text(), ".", part_text()};
				for (int i = 0; i < s.len(); i++)
					text.push_back(s[i]);
				if (kind >= 75) begin
					case ($urandom_range(0, 5))
						0: text.insert($urandom_range(0, text.size()),
							CHAR_W'($urandom_range(1, 255)));
						1: text.delete($urandom_range(0, text.size() - 1));
						2: text.insert(0, CHAR_ZERO);
						3: repeat ($urandom_range(1, 8))
							text.insert(0, CHAR_ZERO + CHAR_W'($urandom_range(1, 9)));
						4: begin
							text.push_back(CHAR_DOT);
							if ($urandom_range(0, 1) == 1)
								text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
						end
						default: repeat ($urandom_range(1, 3))
							if (text.size() > 0)
								void'(text.pop_back());
					endcase
				end
			end
			send_version(text, 1'b0, R_NONE);
		end
		in_valid <= 1'b0;

		while (pending_versions.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_versions.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin : take_results
		int hold_left;
		bit out_quiet;
		svp_result_t want;
		hold_left = 0;
		out_quiet = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_versions.size() == 0)
					flag_mismatch($sformatf("unexpected word status=%0d %0d.%0d.%0d",
						status, major, minor, patch));
				else begin
					want = pending_versions.pop_front();
					if (status !== want.status || major !== want.major ||
							minor !== want.minor || patch !== want.patch)
						flag_mismatch($sformatf(
							"exp status=%0d %0d.%0d.%0d got status=%0d %0d.%0d.%0d",
							want.status, want.major, want.minor, want.patch,
							status, major, minor, patch));
				end
				results_taken++;
				// hold off long enough for the parser to back up into its input
				if (results_taken == 25 || results_taken == 150)
					hold_left = LONG_HOLD;
				else begin
					if ($urandom_range(0, 15) == 0)
						out_quiet = !out_quiet;
					hold_left = out_quiet ? 0 : $urandom_range(0, 12);
				end
			end
			out_stall <= (hold_left > 0);
			if (hold_left > 0)
				hold_left--;
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("testbench: FAIL");
		$finish;
	end

endmodule
